// File: rtl/altp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// altp_pkg
// Shared types and constants of the acceleration limited trajectory predictor.
// ----------------------------------------------------------------------------
package altp_pkg;

    // configuration register indexes
    localparam logic [1:0] REG_POINT_COUNT = 2'd0;
    localparam logic [1:0] REG_TIME_STEP   = 2'd1;

    // datapath operations
    localparam logic [4:0] OP_NOP       = 5'd0;
    localparam logic [4:0] OP_LOAD      = 5'd1;
    localparam logic [4:0] OP_MUL_STEP  = 5'd2;
    localparam logic [4:0] OP_SET_STEP  = 5'd3;
    localparam logic [4:0] OP_DIFF      = 5'd4;
    localparam logic [4:0] OP_MUL_SQ    = 5'd5;
    localparam logic [4:0] OP_ACC       = 5'd6;
    localparam logic [4:0] OP_SQRT_INIT = 5'd7;
    localparam logic [4:0] OP_SQRT_IT   = 5'd8;
    localparam logic [4:0] OP_SNAP      = 5'd9;
    localparam logic [4:0] OP_MUL_DIV   = 5'd10;
    localparam logic [4:0] OP_DIV_INIT  = 5'd11;
    localparam logic [4:0] OP_DIV_IT    = 5'd12;
    localparam logic [4:0] OP_DIV_APPLY = 5'd13;
    localparam logic [4:0] OP_MUL_POS   = 5'd14;
    localparam logic [4:0] OP_POS       = 5'd15;
    localparam logic [4:0] OP_COR_INIT  = 5'd16;
    localparam logic [4:0] OP_COR_IT    = 5'd17;
    localparam logic [4:0] OP_EMIT      = 5'd18;

    // 0.01 in q16.16, truncated
    localparam logic [32:0] DIFF_EPS = 33'd655;
    localparam int unsigned SQRT_STEPS = 32;
    localparam int unsigned DIV_STEPS = 33;
    localparam int unsigned CORDIC_STEPS = 16;
    // angles in units of 2^-24 turn
    localparam logic signed [25:0] HALF_TURN = 26'sd8388608;
    localparam logic signed [25:0] ANG_ROUND = 26'sd128;

    localparam logic [21:0] ATAN_UNITS [CORDIC_STEPS] = '{
        22'd2097152, 22'd1238021, 22'd654136, 22'd332050,
        22'd166669,  22'd83416,   22'd41718,  22'd20860,
        22'd10430,   22'd5215,    22'd2608,   22'd1304,
        22'd652,     22'd326,     22'd163,    22'd81
    };

    typedef struct packed {
        logic [4:0] op;
        logic [1:0] comp;
        logic [5:0] iter;
        logic [3:0] index;
        logic       last;
    } cmd_t;

    typedef struct packed {
        logic mag_big;
        logic step_ge;
    } stat_t;

endpackage

// File: rtl/accel_limited_trajectory_predict_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accel_limited_trajectory_predict_unit
// Acceleration limited trajectory predictor, q16.16, Euler integration.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; the block then emits
// point_count points (0 gives one, above MAX_POINTS gives MAX_POINTS), each on
// the result ports for exactly one cycle with valid high, and the receiver
// cannot stall them. Each point keeps its velocity when it is already within
// 0.01 of the target, snaps to the target when the step reaches the
// difference, and is limited otherwise: the latter runs three restoring
// divides on top of the square root and the 16-step CORDIC heading; the
// divides share one 34x34 multiplier with the squaring and position steps.
// busy drops in the cycle the last point is shown; configuration writes belong in the idle time.
module accel_limited_trajectory_predict_unit #(
    parameter int MAX_POINTS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               wr_en,
    input  logic [1:0]         wr_index,
    input  logic [15:0]        wr_data,
    input  logic signed [31:0] start_pos_x,
    input  logic signed [31:0] start_pos_y,
    input  logic signed [31:0] start_pos_z,
    input  logic signed [31:0] start_vel_x,
    input  logic signed [31:0] start_vel_y,
    input  logic signed [31:0] start_vel_z,
    input  logic signed [31:0] target_vel_x,
    input  logic signed [31:0] target_vel_y,
    input  logic signed [31:0] target_vel_z,
    input  logic [30:0]        accel_limit,
    output logic               valid,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y,
    output logic signed [31:0] pos_z,
    output logic signed [31:0] vel_x,
    output logic signed [31:0] vel_y,
    output logic signed [31:0] vel_z,
    output logic signed [15:0] heading,
    output logic [3:0]         point_index,
    output logic               last_point
);
    import altp_pkg::*;

    logic [4:0]  point_count_reg;
    logic [15:0] time_step_reg;
    cmd_t        cmd;
    stat_t       stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg <= 5'd8;
            time_step_reg   <= 16'd8192;
        end
        else if (wr_en)
        begin
            if (wr_index == REG_POINT_COUNT)
                point_count_reg <= wr_data[4:0];
            else if (wr_index == REG_TIME_STEP)
                time_step_reg <= wr_data;
        end
    end

    altp_ctrl #(
        .MAX_POINTS (MAX_POINTS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .point_count (point_count_reg),
        .stat        (stat),
        .cmd         (cmd),
        .busy        (busy),
        .valid       (valid)
    );

    altp_dpath u_dpath (
        .clk          (clk),
        .cmd          (cmd),
        .stat         (stat),
        .time_step    (time_step_reg),
        .start_pos_x  (start_pos_x),
        .start_pos_y  (start_pos_y),
        .start_pos_z  (start_pos_z),
        .start_vel_x  (start_vel_x),
        .start_vel_y  (start_vel_y),
        .start_vel_z  (start_vel_z),
        .target_vel_x (target_vel_x),
        .target_vel_y (target_vel_y),
        .target_vel_z (target_vel_z),
        .accel_limit  (accel_limit),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .vel_x        (vel_x),
        .vel_y        (vel_y),
        .vel_z        (vel_z),
        .heading      (heading),
        .point_index  (point_index),
        .last_point   (last_point)
    );

endmodule

// File: rtl/altp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// altp_ctrl
// Sequencer: walks each point through difference, magnitude, limiting,
// integration and heading, and issues at most one datapath operation per cycle.
// ----------------------------------------------------------------------------
module altp_ctrl #(
    parameter int MAX_POINTS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [4:0]         point_count,
    input  altp_pkg::stat_t    stat,
    output altp_pkg::cmd_t     cmd,
    output logic               busy,
    output logic               valid
);
    import altp_pkg::*;

    localparam int CW = $clog2(MAX_POINTS + 1);

    localparam logic [4:0] S_IDLE      = 5'd0;
    localparam logic [4:0] S_STEP_MUL  = 5'd1;
    localparam logic [4:0] S_STEP_SET  = 5'd2;
    localparam logic [4:0] S_DIFF      = 5'd3;
    localparam logic [4:0] S_SQ_MUL    = 5'd4;
    localparam logic [4:0] S_SQ_ACC    = 5'd5;
    localparam logic [4:0] S_SQRT_INIT = 5'd6;
    localparam logic [4:0] S_SQRT_IT   = 5'd7;
    localparam logic [4:0] S_DECIDE    = 5'd8;
    localparam logic [4:0] S_SNAP      = 5'd9;
    localparam logic [4:0] S_DIV_MUL   = 5'd10;
    localparam logic [4:0] S_DIV_INIT  = 5'd11;
    localparam logic [4:0] S_DIV_IT    = 5'd12;
    localparam logic [4:0] S_DIV_APPLY = 5'd13;
    localparam logic [4:0] S_POS_MUL   = 5'd14;
    localparam logic [4:0] S_POS_ADD   = 5'd15;
    localparam logic [4:0] S_COR_INIT  = 5'd16;
    localparam logic [4:0] S_COR_IT    = 5'd17;
    localparam logic [4:0] S_EMIT      = 5'd18;

    logic [4:0]    state_reg, state_next;
    logic [1:0]    comp_reg, comp_next;
    logic [5:0]    iter_reg, iter_next;
    logic [CW-1:0] k_reg, k_next;
    logic [CW-1:0] n_reg, n_next;
    logic          valid_reg, valid_next;
    logic          last;
    logic [CW-1:0] n_req;

    assign last = (CW'(k_reg + 1'b1) == n_reg);

    always_comb
    begin
        if (32'(point_count) > 32'(MAX_POINTS))
            n_req = CW'(MAX_POINTS);
        else if (point_count == 5'd0)
            n_req = CW'(1);
        else
            n_req = CW'(point_count);
    end

    always_comb
    begin
        state_next = state_reg;
        comp_next  = comp_reg;
        iter_next  = iter_reg;
        k_next     = k_reg;
        n_next     = n_reg;
        valid_next = 1'b0;
        cmd.op     = OP_NOP;
        cmd.comp   = comp_reg;
        cmd.iter   = iter_reg;
        cmd.index  = 4'(k_reg);
        cmd.last   = last;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.op     = OP_LOAD;
                    k_next     = '0;
                    n_next     = n_req;
                    state_next = S_STEP_MUL;
                end
            end
            S_STEP_MUL:
            begin
                cmd.op     = OP_MUL_STEP;
                state_next = S_STEP_SET;
            end
            S_STEP_SET:
            begin
                cmd.op     = OP_SET_STEP;
                state_next = S_DIFF;
            end
            S_DIFF:
            begin
                cmd.op     = OP_DIFF;
                comp_next  = 2'd0;
                state_next = S_SQ_MUL;
            end
            S_SQ_MUL:
            begin
                cmd.op     = OP_MUL_SQ;
                state_next = S_SQ_ACC;
            end
            S_SQ_ACC:
            begin
                cmd.op = OP_ACC;
                if (comp_reg == 2'd2)
                    state_next = S_SQRT_INIT;
                else
                begin
                    comp_next  = comp_reg + 2'd1;
                    state_next = S_SQ_MUL;
                end
            end
            S_SQRT_INIT:
            begin
                cmd.op     = OP_SQRT_INIT;
                iter_next  = '0;
                state_next = S_SQRT_IT;
            end
            S_SQRT_IT:
            begin
                cmd.op = OP_SQRT_IT;
                if (iter_reg == 6'(SQRT_STEPS - 1))
                    state_next = S_DECIDE;
                else
                    iter_next = iter_reg + 6'd1;
            end
            S_DECIDE:
            begin
                comp_next = 2'd0;
                priority if (!stat.mag_big)
                    state_next = S_POS_MUL;
                else if (stat.step_ge)
                    state_next = S_SNAP;
                else
                    state_next = S_DIV_MUL;
            end
            S_SNAP:
            begin
                cmd.op     = OP_SNAP;
                comp_next  = 2'd0;
                state_next = S_POS_MUL;
            end
            S_DIV_MUL:
            begin
                cmd.op     = OP_MUL_DIV;
                state_next = S_DIV_INIT;
            end
            S_DIV_INIT:
            begin
                cmd.op     = OP_DIV_INIT;
                iter_next  = '0;
                state_next = S_DIV_IT;
            end
            S_DIV_IT:
            begin
                cmd.op = OP_DIV_IT;
                if (iter_reg == 6'(DIV_STEPS - 1))
                    state_next = S_DIV_APPLY;
                else
                    iter_next = iter_reg + 6'd1;
            end
            S_DIV_APPLY:
            begin
                cmd.op = OP_DIV_APPLY;
                if (comp_reg == 2'd2)
                begin
                    comp_next  = 2'd0;
                    state_next = S_POS_MUL;
                end
                else
                begin
                    comp_next  = comp_reg + 2'd1;
                    state_next = S_DIV_MUL;
                end
            end
            S_POS_MUL:
            begin
                cmd.op     = OP_MUL_POS;
                state_next = S_POS_ADD;
            end
            S_POS_ADD:
            begin
                cmd.op = OP_POS;
                if (comp_reg == 2'd2)
                    state_next = S_COR_INIT;
                else
                begin
                    comp_next  = comp_reg + 2'd1;
                    state_next = S_POS_MUL;
                end
            end
            S_COR_INIT:
            begin
                cmd.op     = OP_COR_INIT;
                iter_next  = '0;
                state_next = S_COR_IT;
            end
            S_COR_IT:
            begin
                cmd.op = OP_COR_IT;
                if (iter_reg == 6'(CORDIC_STEPS - 1))
                    state_next = S_EMIT;
                else
                    iter_next = iter_reg + 6'd1;
            end
            S_EMIT:
            begin
                cmd.op     = OP_EMIT;
                valid_next = 1'b1;
                if (last)
                    state_next = S_IDLE;
                else
                begin
                    k_next     = CW'(k_reg + 1'b1);
                    state_next = S_DIFF;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            comp_reg  <= '0;
            iter_reg  <= '0;
            k_reg     <= '0;
            n_reg     <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            comp_reg  <= comp_next;
            iter_reg  <= iter_next;
            k_reg     <= k_next;
            n_reg     <= n_next;
            valid_reg <= valid_next;
        end
    end

    assign busy  = (state_reg != S_IDLE);
    assign valid = valid_reg;

endmodule

// File: rtl/altp_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// altp_dpath
// Datapath: shared multiplier, bit-serial square root and divider, CORDIC
// heading unit, and the position, velocity and result registers.
// ----------------------------------------------------------------------------
module altp_dpath (
    input  logic                clk,
    input  altp_pkg::cmd_t      cmd,
    output altp_pkg::stat_t     stat,
    input  logic [15:0]         time_step,
    input  logic signed [31:0]  start_pos_x,
    input  logic signed [31:0]  start_pos_y,
    input  logic signed [31:0]  start_pos_z,
    input  logic signed [31:0]  start_vel_x,
    input  logic signed [31:0]  start_vel_y,
    input  logic signed [31:0]  start_vel_z,
    input  logic signed [31:0]  target_vel_x,
    input  logic signed [31:0]  target_vel_y,
    input  logic signed [31:0]  target_vel_z,
    input  logic [30:0]         accel_limit,
    output logic signed [31:0]  pos_x,
    output logic signed [31:0]  pos_y,
    output logic signed [31:0]  pos_z,
    output logic signed [31:0]  vel_x,
    output logic signed [31:0]  vel_y,
    output logic signed [31:0]  vel_z,
    output logic signed [15:0]  heading,
    output logic [3:0]          point_index,
    output logic                last_point
);
    import altp_pkg::*;

    logic signed [31:0] pos_reg [3];
    logic signed [31:0] vel_reg [3];
    logic signed [31:0] tgt_reg [3];
    logic [32:0]        ad_reg [3];
    logic [2:0]         dneg_reg;
    logic               s_reg;
    logic [30:0]        limit_reg;
    logic [30:0]        step_reg;
    logic [63:0]        prod_reg;
    logic [63:0]        sum_reg;
    logic [63:0]        rad_reg;
    logic [63:0]        root_reg;
    logic [63:0]        bit_reg;
    logic [32:0]        rem_reg;
    logic [32:0]        quo_reg;
    logic signed [35:0] cx_reg;
    logic signed [35:0] cy_reg;
    logic signed [25:0] ang_reg;

    logic signed [31:0] pos_out_reg [3];
    logic signed [31:0] vel_out_reg [3];
    logic signed [15:0] heading_reg;
    logic [3:0]         index_reg;
    logic               last_reg;

    // difference to target, magnitude and limit
    logic signed [32:0] d [3];
    logic [32:0]        ad [3];
    logic               s_any;
    logic [32:0]        mag;
    logic [32:0]        sq_op;

    always_comb
    begin
        s_any = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            d[i]  = 33'(tgt_reg[i]) - 33'(vel_reg[i]);
            ad[i] = d[i][32] ? 33'(-d[i]) : 33'(d[i]);
            if (ad[i][32] || ad[i][31])
                s_any = 1'b1;
        end
    end

    assign mag = s_reg ? {root_reg[31:0], 1'b0} : {1'b0, root_reg[31:0]};
    assign stat.mag_big = (mag > DIFF_EPS);
    assign stat.step_ge = ({2'b00, step_reg} >= mag);
    assign sq_op = s_reg ? (ad_reg[cmd.comp] >> 1) : ad_reg[cmd.comp];

    // shared multiplier
    logic signed [33:0] ma, mb;
    logic signed [67:0] mprod;

    always_comb
    begin
        ma = '0;
        mb = '0;
        unique case (cmd.op)
            OP_MUL_STEP:
            begin
                ma = {3'b000, limit_reg};
                mb = {18'd0, time_step};
            end
            OP_MUL_SQ:
            begin
                ma = {1'b0, sq_op};
                mb = {1'b0, sq_op};
            end
            OP_MUL_DIV:
            begin
                ma = {1'b0, ad_reg[cmd.comp]};
                mb = {3'b000, step_reg};
            end
            OP_MUL_POS:
            begin
                ma = 34'(vel_reg[cmd.comp]);
                mb = {18'd0, time_step};
            end
            default:
            begin
                ma = '0;
                mb = '0;
            end
        endcase
    end

    assign mprod = ma * mb;

    // square root step
    logic [63:0] sq_trial;
    assign sq_trial = root_reg + bit_reg;

    // divider step
    logic [33:0] dv_t;
    logic        dv_ge;
    logic [33:0] dv_sub;
    assign dv_t   = {rem_reg, quo_reg[32]};
    assign dv_ge  = (dv_t >= {1'b0, mag});
    assign dv_sub = dv_t - {1'b0, mag};

    // velocity update and position integration
    logic signed [33:0] vel_upd;
    logic signed [32:0] pos_sum;
    logic signed [31:0] pos_sat;
    logic signed [31:0] pos_inc;

    assign vel_upd = 34'(vel_reg[cmd.comp])
                   + (dneg_reg[cmd.comp] ? -{1'b0, quo_reg} : {1'b0, quo_reg});
    assign pos_inc = prod_reg[47:16];
    assign pos_sum = 33'(pos_reg[cmd.comp]) + 33'(pos_inc);

    always_comb
    begin
        if (pos_sum[32] != pos_sum[31])
            pos_sat = pos_sum[32] ? 32'sh80000000 : 32'sh7fffffff;
        else
            pos_sat = pos_sum[31:0];
    end

    // cordic vectoring on (vel_z, vel_x)
    logic signed [35:0] cx_sh, cy_sh;
    logic signed [25:0] atan_i;
    logic               vz_neg;
    logic signed [35:0] vz_ext, vx_ext;
    logic signed [25:0] ang_rnd;
    logic signed [15:0] heading_calc;

    assign cx_sh  = cx_reg >>> cmd.iter[3:0];
    assign cy_sh  = cy_reg >>> cmd.iter[3:0];
    assign atan_i = {4'b0000, ATAN_UNITS[cmd.iter[3:0]]};
    assign vz_neg = vel_reg[2][31];
    assign vz_ext = 36'(vel_reg[2]);
    assign vx_ext = 36'(vel_reg[0]);
    assign ang_rnd = ang_reg + ANG_ROUND;

    always_comb
    begin
        if (vel_reg[0] == 32'sd0)
            heading_calc = vz_neg ? 16'sh8000 : 16'sh0000;
        else
            heading_calc = ang_rnd[23:8];
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_NOP:
            begin
            end
            OP_LOAD:
            begin
                pos_reg[0] <= start_pos_x;
                pos_reg[1] <= start_pos_y;
                pos_reg[2] <= start_pos_z;
                vel_reg[0] <= start_vel_x;
                vel_reg[1] <= start_vel_y;
                vel_reg[2] <= start_vel_z;
                tgt_reg[0] <= target_vel_x;
                tgt_reg[1] <= target_vel_y;
                tgt_reg[2] <= target_vel_z;
                limit_reg  <= accel_limit;
            end
            OP_MUL_STEP, OP_MUL_SQ, OP_MUL_DIV, OP_MUL_POS:
            begin
                prod_reg <= mprod[63:0];
            end
            OP_SET_STEP:
            begin
                step_reg <= prod_reg[46:16];
            end
            OP_DIFF:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    ad_reg[i]   <= ad[i];
                    dneg_reg[i] <= d[i][32];
                end
                s_reg   <= s_any;
                sum_reg <= '0;
            end
            OP_ACC:
            begin
                sum_reg <= sum_reg + prod_reg;
            end
            OP_SQRT_INIT:
            begin
                rad_reg  <= sum_reg;
                root_reg <= '0;
                bit_reg  <= 64'd1 << 62;
            end
            OP_SQRT_IT:
            begin
                if (rad_reg >= sq_trial)
                begin
                    rad_reg  <= rad_reg - sq_trial;
                    root_reg <= (root_reg >> 1) + bit_reg;
                end
                else
                    root_reg <= root_reg >> 1;
                bit_reg <= bit_reg >> 2;
            end
            OP_SNAP:
            begin
                for (int i = 0; i < 3; i++)
                    vel_reg[i] <= tgt_reg[i];
            end
            OP_DIV_INIT:
            begin
                // quotient stays below 2^33, so the top bits start as remainder
                rem_reg <= {2'b00, prod_reg[63:33]};
                quo_reg <= prod_reg[32:0];
            end
            OP_DIV_IT:
            begin
                rem_reg <= dv_ge ? dv_sub[32:0] : dv_t[32:0];
                quo_reg <= {quo_reg[31:0], dv_ge};
            end
            OP_DIV_APPLY:
            begin
                vel_reg[cmd.comp] <= vel_upd[31:0];
            end
            OP_POS:
            begin
                pos_reg[cmd.comp] <= pos_sat;
            end
            OP_COR_INIT:
            begin
                cx_reg  <= vz_neg ? -vz_ext : vz_ext;
                cy_reg  <= vz_neg ? -vx_ext : vx_ext;
                ang_reg <= vz_neg ? HALF_TURN : 26'sd0;
            end
            OP_COR_IT:
            begin
                if (cy_reg > 36'sd0)
                begin
                    cx_reg  <= cx_reg + cy_sh;
                    cy_reg  <= cy_reg - cx_sh;
                    ang_reg <= ang_reg + atan_i;
                end
                else
                begin
                    cx_reg  <= cx_reg - cy_sh;
                    cy_reg  <= cy_reg + cx_sh;
                    ang_reg <= ang_reg - atan_i;
                end
            end
            OP_EMIT:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    pos_out_reg[i] <= pos_reg[i];
                    vel_out_reg[i] <= vel_reg[i];
                end
                heading_reg <= heading_calc;
                index_reg   <= cmd.index;
                last_reg    <= cmd.last;
            end
            default:
            begin
            end
        endcase
    end

    assign pos_x       = pos_out_reg[0];
    assign pos_y       = pos_out_reg[1];
    assign pos_z       = pos_out_reg[2];
    assign vel_x       = vel_out_reg[0];
    assign vel_y       = vel_out_reg[1];
    assign vel_z       = vel_out_reg[2];
    assign heading     = heading_reg;
    assign point_index = index_reg;
    assign last_point  = last_reg;

endmodule

// File: rtl/altp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// altp_checker
// Port-level checks of the request and result sequencing.
// ----------------------------------------------------------------------------
module altp_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic valid,
    input logic last_point
);

    // a taken request keeps the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("request accepted but busy not raised");

    // the final point frees the block
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        valid && last_point |-> !busy)
        else $error("busy still high on final point");

    // more points follow while busy
    a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !last_point |-> busy)
        else $error("intermediate point shown while idle");

    // points are never shown back to back
    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        valid |=> !valid)
        else $error("result strobe held for two cycles");

endmodule

bind accel_limited_trajectory_predict_unit altp_checker u_altp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .valid      (valid),
    .last_point (last_point)
);
